>>> sv/guillotine_rect_allocator_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the guillotine rectangle allocator
// Implication checks on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef GUILLOTINE_RECT_ALLOCATOR_ASSERT_SVH
`define GUILLOTINE_RECT_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define GRA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GRA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/gra_pkg.sv
// ---------------------------------------------------------------------------
// gra_pkg
// Types, codes and constants shared by the rectangle allocator modules.
// ---------------------------------------------------------------------------
package gra_pkg;

  localparam int MAX_NODES_DEF = 256;
  localparam int PC_W          = 5;

  localparam logic [14:0] ATLAS_MAX   = 15'd16384;
  localparam logic [14:0] ATLAS_RESET = 15'd1024;

  // opcodes
  localparam logic OP_PACK  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // configuration register indexes
  localparam logic CFG_ATLAS_W = 1'b0;
  localparam logic CFG_ATLAS_H = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic        opcode;
    logic [14:0] req_width;
    logic [14:0] req_height;
  } gra_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [13:0] pos_x;
    logic [13:0] pos_y;
  } gra_res_t;

  typedef struct packed {
    logic        used;
    logic [13:0] x;
    logic [13:0] y;
    logic [14:0] w;
    logic [14:0] h;
  } gra_node_t;

  // branch conditions of the sequencer
  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_IN,
    C_CLR,
    C_SCAN_MORE,
    C_HIT,
    C_FULL,
    C_EXACT,
    C_HMATCH,
    C_WMATCH,
    C_OUT_BUSY
  } gra_cond_e;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_CLR,
    WR_RIGHT,
    WR_RIGHT_FULL,
    WR_BOTTOM,
    WR_OWN
  } gra_wr_e;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_ONE,
    CNT_INC
  } gra_cnt_e;

  typedef enum logic [1:0] {
    RS_HOLD,
    RS_NOFIT,
    RS_FULL,
    RS_PLACED
  } gra_rs_e;

  typedef struct packed {
    gra_cond_e        cond;
    logic [PC_W-1:0]  target;
    gra_wr_e          wr_sel;
    gra_cnt_e         cnt_op;
    gra_rs_e          rs_sel;
    logic             accept;
    logic             scan;
    logic             emit;
  } gra_ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic op_clr;
    logic scan_more;
    logic hit;
    logic full;
    logic exact;
    logic hmatch;
    logic wmatch;
    logic out_busy;
  } gra_flags_t;

endpackage

>>> sv/guillotine_rect_allocator.sv
// ---------------------------------------------------------------------------
// guillotine_rect_allocator
// First-fit guillotine rectangle allocator for a 2-D atlas.
// ---------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid_i/in_stall_o/in_data_i) takes one request item:
//  pack a rectangle or clear the table. Output channel (out_valid_o/
//  out_stall_i/out_data_o) returns one result item per request.
//  cfg_we_i/cfg_idx_i/cfg_wdata_i write the atlas size; it is used at the
//  next clear (and reset builds a 1024x1024 table).
//  One item at a time. A pack scans the node table one entry per cycle
//  through the node memory read port, up to the node count (at most
//  MAX_NODES entries). After the result is registered, the block passes
//  through a done step before it is ready again.
//  The result sits in an output register; a stalled receiver holds it there
//  and the next item is still accepted and worked on, but its result waits
//  in the emit step until the register frees up.
//  Reset: empty output, node table = one free atlas node, no clearing pass.
// ---------------------------------------------------------------------------
`include "guillotine_rect_allocator_assert.svh"

module guillotine_rect_allocator #(
  parameter int MAX_NODES = gra_pkg::MAX_NODES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gra_pkg::gra_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gra_pkg::gra_res_t out_data_o,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [14:0]       cfg_wdata_i
);
  import gra_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  localparam gra_node_t RESET_NODE = '{
    used: 1'b0, x: 14'd0, y: 14'd0, w: ATLAS_RESET, h: ATLAS_RESET
  };

  function automatic logic [14:0] clamp_size(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v == 15'd0) begin
      r = 15'd1;
    end else if (v > ATLAS_MAX) begin
      r = ATLAS_MAX;
    end
    return r;
  endfunction

  gra_ctrl_t  ctrl;
  gra_flags_t flags;

  gra_req_t   req_q;
  gra_res_t   res_q, out_q;
  logic       out_valid_q;
  logic [14:0] atlas_w_q, atlas_h_q;
  logic [CW-1:0] count_q;
  logic       init0_q, rd_init_q;
  logic [IW-1:0] cur_q, rd_addr;

  logic       mem_we;
  logic [IW-1:0] mem_waddr;
  gra_node_t  mem_wdata, mem_rdata, node;

  logic       in_acc, out_busy, hit, scan_more, exact, hmatch, wmatch, full;
  logic [1:0] need;

  gra_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  gra_node_mem #(
    .DEPTH (MAX_NODES),
    .AW    (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = !ctrl.accept;
  assign in_acc     = in_valid_i && ctrl.accept;
  assign out_busy   = out_valid_q && out_stall_i;

  // entry 0 reads as the reset node until it is first written
  assign node = rd_init_q ? RESET_NODE : mem_rdata;

  assign hit       = !node.used && (req_q.req_width <= node.w)
                     && (req_q.req_height <= node.h);
  assign scan_more = (CW'(cur_q) + CW'(1)) < count_q;
  assign wmatch    = req_q.req_width == node.w;
  assign hmatch    = req_q.req_height == node.h;
  assign exact     = wmatch && hmatch;
  assign need      = exact ? 2'd0 : ((wmatch || hmatch) ? 2'd1 : 2'd2);
  assign full      = ({1'b0, count_q} + (CW+1)'(need)) > (CW+1)'(MAX_NODES);

  assign flags = '{
    in_acc:    in_acc,
    op_clr:    req_q.opcode == OP_CLEAR,
    scan_more: scan_more,
    hit:       hit,
    full:      full,
    exact:     exact,
    hmatch:    hmatch,
    wmatch:    wmatch,
    out_busy:  out_busy
  };

  // read address: entry 0 while waiting, step forward during the scan
  always_comb begin
    if (ctrl.accept) begin
      rd_addr = '0;
    end else if (ctrl.scan && scan_more && !hit) begin
      rd_addr = cur_q + 1'b1;
    end else begin
      rd_addr = cur_q;
    end
  end

  always_comb begin
    mem_we    = ctrl.wr_sel != WR_NONE;
    mem_waddr = count_q[IW-1:0];
    mem_wdata = node;
    case (ctrl.wr_sel)
      WR_CLR: begin
        mem_waddr = '0;
        mem_wdata = '{used: 1'b0, x: 14'd0, y: 14'd0,
                      w: clamp_size(atlas_w_q), h: clamp_size(atlas_h_q)};
      end
      WR_RIGHT: begin
        mem_wdata = '{used: 1'b0, x: node.x + req_q.req_width[13:0], y: node.y,
                      w: node.w - req_q.req_width, h: req_q.req_height};
      end
      WR_RIGHT_FULL: begin
        mem_wdata = '{used: 1'b0, x: node.x + req_q.req_width[13:0], y: node.y,
                      w: node.w - req_q.req_width, h: node.h};
      end
      WR_BOTTOM: begin
        mem_wdata = '{used: 1'b0, x: node.x, y: node.y + req_q.req_height[13:0],
                      w: node.w, h: node.h - req_q.req_height};
      end
      WR_OWN: begin
        mem_waddr = cur_q;
        mem_wdata = '{used: 1'b1, x: node.x, y: node.y,
                      w: req_q.req_width, h: req_q.req_height};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= ATLAS_RESET;
      atlas_h_q <= ATLAS_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_ATLAS_W) begin
        atlas_w_q <= cfg_wdata_i;
      end
      if (cfg_idx_i == CFG_ATLAS_H) begin
        atlas_h_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= CW'(1);
      init0_q   <= 1'b1;
      rd_init_q <= 1'b1;
      cur_q     <= '0;
    end else begin
      case (ctrl.cnt_op)
        CNT_ONE:  count_q <= CW'(1);
        CNT_INC:  count_q <= count_q + CW'(1);
        default:  count_q <= count_q;
      endcase
      if (mem_we && (mem_waddr == '0)) begin
        init0_q <= 1'b0;
      end
      rd_init_q <= init0_q && (rd_addr == '0);
      cur_q     <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_data_i;
      res_q <= '0;
    end else begin
      case (ctrl.rs_sel)
        RS_NOFIT:  res_q.status <= ST_NOFIT;
        RS_FULL:   res_q.status <= ST_FULL;
        RS_PLACED: res_q <= '{status: ST_OK, pos_x: node.x, pos_y: node.y};
        default:   res_q <= res_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit && !out_busy) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit && !out_busy) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `GRA_ASSERT_IMP(a_count_range, 1'b1,
                  (count_q != '0) && (count_q <= CW'(MAX_NODES)),
                  "node count out of range")
  `GRA_ASSERT_NXT(a_busy_after_accept, in_acc, in_stall_o,
                  "input taken while an item is in work")
  `GRA_ASSERT_IMP(a_own_on_fit, ctrl.wr_sel == WR_OWN, hit,
                  "node claimed that does not fit the request")
  `GRA_ASSERT_IMP(a_append_room,
                  (ctrl.wr_sel == WR_RIGHT) || (ctrl.wr_sel == WR_RIGHT_FULL) ||
                  (ctrl.wr_sel == WR_BOTTOM),
                  count_q < CW'(MAX_NODES),
                  "node appended to a full table")

endmodule

>>> sv/gra_node_mem.sv
// ---------------------------------------------------------------------------
// gra_node_mem
// Node table storage: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module gra_node_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  gra_pkg::gra_node_t  wdata_i,
  input  logic [AW-1:0]       raddr_i,
  output gra_pkg::gra_node_t  rdata_o
);
  import gra_pkg::*;

  gra_node_t mem [DEPTH];
  gra_node_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/gra_sequencer.sv
// ---------------------------------------------------------------------------
// gra_sequencer
// Step counter and control store; evaluates one branch condition per step.
// ---------------------------------------------------------------------------
module gra_sequencer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gra_pkg::gra_flags_t flags_i,
  output gra_pkg::gra_ctrl_t  ctrl_o
);
  import gra_pkg::*;

  localparam logic [PC_W-1:0] P_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] P_DEC     = 5'd1;
  localparam logic [PC_W-1:0] P_SCAN    = 5'd2;
  localparam logic [PC_W-1:0] P_HITCHK  = 5'd3;
  localparam logic [PC_W-1:0] P_MISS    = 5'd4;
  localparam logic [PC_W-1:0] P_FIT     = 5'd5;
  localparam logic [PC_W-1:0] P_EXCHK   = 5'd6;
  localparam logic [PC_W-1:0] P_HCHK    = 5'd7;
  localparam logic [PC_W-1:0] P_WCHK    = 5'd8;
  localparam logic [PC_W-1:0] P_RIGHT   = 5'd9;
  localparam logic [PC_W-1:0] P_BOTTOM  = 5'd10;
  localparam logic [PC_W-1:0] P_RIGHTF  = 5'd11;
  localparam logic [PC_W-1:0] P_OWN     = 5'd12;
  localparam logic [PC_W-1:0] P_EMIT    = 5'd13;
  localparam logic [PC_W-1:0] P_DONE    = 5'd14;
  localparam logic [PC_W-1:0] P_CLR     = 5'd15;
  localparam logic [PC_W-1:0] P_FULL    = 5'd16;

  localparam gra_ctrl_t CTRL_NOP = '{
    cond:   C_NEXT,
    target: P_IDLE,
    wr_sel: WR_NONE,
    cnt_op: CNT_HOLD,
    rs_sel: RS_HOLD,
    accept: 1'b0,
    scan:   1'b0,
    emit:   1'b0
  };

  function automatic gra_ctrl_t ucode(input logic [PC_W-1:0] pc);
    gra_ctrl_t c;
    c = CTRL_NOP;
    case (pc)
      P_IDLE: begin
        c.cond = C_NO_IN; c.target = P_IDLE; c.accept = 1'b1;
      end
      P_DEC: begin
        c.cond = C_CLR; c.target = P_CLR;
      end
      P_SCAN: begin
        c.cond = C_SCAN_MORE; c.target = P_SCAN; c.scan = 1'b1;
      end
      P_HITCHK: begin
        c.cond = C_HIT; c.target = P_FIT;
      end
      P_MISS: begin
        c.cond = C_ALWAYS; c.target = P_EMIT; c.rs_sel = RS_NOFIT;
      end
      P_FIT: begin
        c.cond = C_FULL; c.target = P_FULL;
      end
      P_EXCHK: begin
        c.cond = C_EXACT; c.target = P_OWN;
      end
      P_HCHK: begin
        c.cond = C_HMATCH; c.target = P_RIGHTF;
      end
      P_WCHK: begin
        c.cond = C_WMATCH; c.target = P_BOTTOM;
      end
      P_RIGHT: begin
        c.wr_sel = WR_RIGHT; c.cnt_op = CNT_INC;
      end
      P_BOTTOM: begin
        c.cond = C_ALWAYS; c.target = P_OWN;
        c.wr_sel = WR_BOTTOM; c.cnt_op = CNT_INC;
      end
      P_RIGHTF: begin
        c.wr_sel = WR_RIGHT_FULL; c.cnt_op = CNT_INC;
      end
      P_OWN: begin
        c.wr_sel = WR_OWN; c.rs_sel = RS_PLACED;
      end
      P_EMIT: begin
        c.cond = C_OUT_BUSY; c.target = P_EMIT; c.emit = 1'b1;
      end
      P_DONE: begin
        c.cond = C_ALWAYS; c.target = P_IDLE;
      end
      P_CLR: begin
        c.cond = C_ALWAYS; c.target = P_EMIT;
        c.wr_sel = WR_CLR; c.cnt_op = CNT_ONE;
      end
      P_FULL: begin
        c.cond = C_ALWAYS; c.target = P_EMIT; c.rs_sel = RS_FULL;
      end
      default: begin
        c.cond = C_ALWAYS; c.target = P_IDLE;
      end
    endcase
    return c;
  endfunction

  logic [PC_W-1:0] pc_q, pc_d;
  gra_ctrl_t       ctrl;
  logic            take;

  always_comb begin
    ctrl = ucode(pc_q);
    case (ctrl.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = !flags_i.in_acc;
      C_CLR:       take = flags_i.op_clr;
      C_SCAN_MORE: take = flags_i.scan_more && !flags_i.hit;
      C_HIT:       take = flags_i.hit;
      C_FULL:      take = flags_i.full;
      C_EXACT:     take = flags_i.exact;
      C_HMATCH:    take = flags_i.hmatch;
      C_WMATCH:    take = flags_i.wmatch;
      C_OUT_BUSY:  take = flags_i.out_busy;
      default:     take = 1'b0;
    endcase
    pc_d = take ? ctrl.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= P_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

>>> bench/guillotine_rect_allocator_tb.sv
// ---------------------------------------------------------------------------
// guillotine_rect_allocator_tb
// Self-checking bench: drives pack and clear requests with random gaps on
// both channels; checks each result against a table entry or an in-bench
// model of the first-fit node table. Atlas size is changed between phases.
// ---------------------------------------------------------------------------
module guillotine_rect_allocator_tb;
  import gra_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 160;
  localparam int HOLD_AT = 300;
  localparam int HOLD_CYCLES = 1000;

  typedef struct packed {
    gra_req_t   req;
    logic [7:0] reps;
    logic       typed;
    gra_res_t   res;
  } dir_row_t;

  // default atlas is 1024x1024 until the first write
  localparam int DIR_ROWS = 15;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{'{OP_PACK,  15'd1024,  15'd1024},  8'd1,   1'b1, '{ST_OK,    14'd0, 14'd0}},
    '{'{OP_PACK,  15'd0,     15'd0},     8'd1,   1'b1, '{ST_NOFIT, 14'd0, 14'd0}},
    '{'{OP_CLEAR, 15'd0,     15'd0},     8'd1,   1'b1, '{ST_OK,    14'd0, 14'd0}},
    '{'{OP_PACK,  15'd1024,  15'd100},   8'd1,   1'b0, '0},
    '{'{OP_PACK,  15'd200,   15'd924},   8'd1,   1'b0, '0},
    '{'{OP_PACK,  15'd16384, 15'd16384}, 8'd1,   1'b1, '{ST_NOFIT, 14'd0, 14'd0}},
    '{'{OP_PACK,  15'd32767, 15'd0},     8'd1,   1'b1, '{ST_NOFIT, 14'd0, 14'd0}},
    '{'{OP_PACK,  15'd1,     15'd16383}, 8'd1,   1'b1, '{ST_NOFIT, 14'd0, 14'd0}},
    '{'{OP_PACK,  15'd0,     15'd0},     8'd1,   1'b0, '0},
    '{'{OP_PACK,  15'd824,   15'd924},   8'd1,   1'b0, '0},
    '{'{OP_CLEAR, 15'd0,     15'd0},     8'd1,   1'b1, '{ST_OK,    14'd0, 14'd0}},
    // pack 1x1 rectangles 220 times into the cleared table
    '{'{OP_PACK,  15'd1,     15'd1},     8'd220, 1'b0, '0},
    '{'{OP_PACK,  15'd32767, 15'd32767}, 8'd1,   1'b1, '{ST_NOFIT, 14'd0, 14'd0}},
    '{'{OP_PACK,  15'd1,     15'd1},     8'd1,   1'b0, '0},
    '{'{OP_CLEAR, 15'd0,     15'd0},     8'd1,   1'b1, '{ST_OK,    14'd0, 14'd0}}
  };

  localparam logic [14:0] PHASE_W [PHASES] = '{15'd64, 15'd0, 15'd16384, 15'd32767,
                                               15'd1, 15'd0};
  localparam logic [14:0] PHASE_H [PHASES] = '{15'd64, 15'd16384, 15'd1, 15'd0,
                                               15'd1, 15'd0};

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  gra_req_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  gra_res_t    out_data_o;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [14:0] cfg_wdata_i;

  guillotine_rect_allocator i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // node table model
  logic [13:0] tbl_x    [NODES];
  logic [13:0] tbl_y    [NODES];
  logic [14:0] tbl_w    [NODES];
  logic [14:0] tbl_h    [NODES];
  logic        tbl_used [NODES];
  int unsigned tbl_count;
  logic [14:0] reg_aw, reg_ah;
  logic [14:0] atlas_now_w, atlas_now_h;

  gra_res_t due_allocs [$];
  int       mismatch_cnt = 0;
  int       alloc_seen = 0;
  int       snd_idle_pct = 29;
  int       rcv_idle_pct = 45;

  function automatic void flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void rebuild_table();
    for (int i = 0; i < NODES; i++) begin
      tbl_x[i] = '0;
      tbl_y[i] = '0;
      tbl_w[i] = '0;
      tbl_h[i] = '0;
      tbl_used[i] = 1'b0;
    end
    atlas_now_w = (reg_aw == 0) ? 15'd1 : (reg_aw > ATLAS_MAX) ? ATLAS_MAX : reg_aw;
    atlas_now_h = (reg_ah == 0) ? 15'd1 : (reg_ah > ATLAS_MAX) ? ATLAS_MAX : reg_ah;
    tbl_w[0] = atlas_now_w;
    tbl_h[0] = atlas_now_h;
    tbl_count = 1;
  endfunction

  function automatic void add_node(logic [13:0] x, logic [13:0] y,
                                   logic [14:0] w, logic [14:0] h);
    if (tbl_count >= NODES) return;
    tbl_x[tbl_count] = x;
    tbl_y[tbl_count] = y;
    tbl_w[tbl_count] = w;
    tbl_h[tbl_count] = h;
    tbl_used[tbl_count] = 1'b0;
    tbl_count++;
  endfunction

  function automatic gra_res_t alloc_predict(gra_req_t r);
    gra_res_t    res;
    int          found;
    int unsigned need;
    logic [13:0] x, y;
    logic [14:0] nw, nh, w, h;
    res = '0;
    found = -1;
    w = r.req_width;
    h = r.req_height;
    if (r.opcode == OP_CLEAR) begin
      rebuild_table();
      return res;
    end
    for (int i = 0; i < int'(tbl_count); i++) begin
      if (found < 0 && !tbl_used[i] && w <= tbl_w[i] && h <= tbl_h[i]) found = i;
    end
    if (found < 0) begin
      res.status = ST_NOFIT;
      return res;
    end
    x = tbl_x[found];
    y = tbl_y[found];
    nw = tbl_w[found];
    nh = tbl_h[found];
    if (w == nw && h == nh) need = 0;
    else if (w == nw || h == nh) need = 1;
    else need = 2;
    // capacity check comes after the search, so no-fit wins
    if (tbl_count + need > NODES) begin
      res.status = ST_FULL;
      return res;
    end
    if (need == 1 && h == nh) begin
      add_node(14'(x + w), y, nw - w, nh);
    end else if (need == 1) begin
      add_node(x, 14'(y + h), nw, nh - h);
    end else if (need == 2) begin
      add_node(14'(x + w), y, nw - w, h);
      add_node(x, 14'(y + h), nw, nh - h);
    end
    tbl_w[found] = w;
    tbl_h[found] = h;
    tbl_used[found] = 1'b1;
    res.status = ST_OK;
    res.pos_x = x;
    res.pos_y = y;
    return res;
  endfunction

  // request extent, mostly small against the current atlas side
  function automatic logic [14:0] rand_extent(logic [14:0] side);
    int k;
    int top;
    k = $urandom_range(0, 19);
    top = (side >> 3) == 0 ? 1 : int'(side >> 3);
    if (k < 8) return 15'($urandom_range(1, top));
    if (k < 11) return 15'($urandom_range(0, 3));
    if (k < 13) return side;
    if (k < 15) return side >> 1;
    if (k < 17) return 15'($urandom_range(0, side));
    if (k < 19) return 15'($urandom_range(0, 32767));
    return ATLAS_MAX;
  endfunction

  task automatic send_req(input gra_req_t r, input logic typed, input gra_res_t want);
    gra_res_t pred;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = alloc_predict(r);
    due_allocs.push_back(typed ? want : pred);
  endtask

  task automatic wait_idle(input int settle);
    int guard;
    guard = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_allocs.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (settle) @(negedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40000000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver: random stall, plus one long hold-off to back up the block
  initial begin : receiver
    logic hold_done;
    hold_done = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && alloc_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_alloc
    gra_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      alloc_seen++;
      if (due_allocs.size() == 0) begin
        flag_error($sformatf("unexpected result status %0d x %0d y %0d",
                             out_data_o.status, out_data_o.pos_x, out_data_o.pos_y));
      end else begin
        want = due_allocs.pop_front();
        if (out_data_o.status !== want.status || out_data_o.pos_x !== want.pos_x ||
            out_data_o.pos_y !== want.pos_y) begin
          flag_error($sformatf("item %0d: exp status %0d x %0d y %0d, got %0d x %0d y %0d",
                               alloc_seen, want.status, want.pos_x, want.pos_y,
                               out_data_o.status, out_data_o.pos_x, out_data_o.pos_y));
        end
      end
    end
  end

  initial begin : stimulus
    gra_req_t req;
    int       n;
    int       seq_len;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ATLAS_W;
    cfg_wdata_i = '0;
    reg_aw = ATLAS_RESET;
    reg_ah = ATLAS_RESET;
    rebuild_table();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int row = 0; row < DIR_ROWS; row++) begin
      for (int rep = 0; rep < int'(DIR_TAB[row].reps); rep++) begin
        send_req(DIR_TAB[row].req, DIR_TAB[row].typed, DIR_TAB[row].res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_idle(4);
      snd_idle_pct = (p < 2) ? 29 : (p < 4) ? 45 : 0;
      rcv_idle_pct = (p < 2) ? 45 : (p < 4) ? 29 : 0;
      // the new atlas size only takes effect at the next clear
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_idx_i <= CFG_ATLAS_W;
      cfg_wdata_i <= (p == PHASES - 1) ? 15'($urandom_range(1, 16384)) : PHASE_W[p];
      @(negedge clk_i);
      reg_aw = cfg_wdata_i;
      cfg_idx_i <= CFG_ATLAS_H;
      cfg_wdata_i <= (p == PHASES - 1) ? 15'($urandom_range(1, 16384)) : PHASE_H[p];
      @(negedge clk_i);
      reg_ah = cfg_wdata_i;
      cfg_we_i <= 1'b0;

      n = 0;
      while (n < PHASE_ITEMS) begin
        seq_len = ($urandom_range(0, 3) == 0) ? $urandom_range(130, 200)
                                              : $urandom_range(3, 60);
        if (n != 0 || $urandom_range(0, 1) == 1) begin
          req = '{OP_CLEAR, 15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767))};
          send_req(req, 1'b0, '0);
          n++;
        end
        for (int k = 0; k < seq_len && n < PHASE_ITEMS; k++) begin
          if ($urandom_range(0, 32) == 0) begin
            req = '{OP_CLEAR, 15'($urandom_range(0, 32767)), 15'($urandom_range(0, 32767))};
          end else begin
            req.opcode = OP_PACK;
            req.req_width = rand_extent(atlas_now_w);
            req.req_height = rand_extent(atlas_now_h);
          end
          send_req(req, 1'b0, '0);
          n++;
        end
      end
    end

    wait_idle(20);
    if (due_allocs.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", due_allocs.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
